@@ src/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Depends on nothing; every other file in src refers to it by scoped names.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CUR_W   = $clog2(CELLS + 1);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] BLANK   = 8'h20;
  localparam logic [7:0] NEWLINE = 8'h0a;
  localparam logic [7:0] NUL     = 8'h00;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_BACK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_PUT       = 3'd1,
    OP_NEWLINE   = 3'd2,
    OP_BACK      = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_READ      = 3'd5,
    OP_READ_NONE = 3'd6
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       ch;
    logic [CUR_W-1:0] idx;
  } cmd_t;

endpackage

@@ src/text_console_writer_core.sv @@
// Text console writer: 80x25 character screen store with a cursor.
// Put, backspace and out-of-range read give their result in the cycle after the
// engine takes the item; an in-range read goes through ST_READ first (registered store read).
// A scroll walks the store with one read and one write port, then blanks the bottom row; clear
// writes one cell a cycle. Throughput is one put per cycle otherwise, while the result side is ready.
// Reset: synchronous; the store is blanked by a pass over every cell with req_ready low.
module text_console_writer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  character,
  input  logic [10:0] cell_index,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [10:0] cursor_cell,
  output logic [7:0]  read_char,
  output logic        scrolled
);

  // Front end to queue.
  logic          push_valid;
  logic          push_ready;
  tcw_pkg::cmd_t push_cmd;

  // Queue to engine.
  logic          pop_valid;
  logic          pop_ready;
  tcw_pkg::cmd_t pop_cmd;

  // High during the blanking pass after reset; hold off new items.
  logic          initializing;

  // Classify incoming items into engine commands.
  tcw_front u_front (
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .mode         (mode),
    .character    (character),
    .cell_index   (cell_index),
    .initializing (initializing),
    .push_ready   (push_ready),
    .push_valid   (push_valid),
    .push_cmd     (push_cmd)
  );

  // Decouple the front end from long engine operations such as scroll.
  tcw_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Execute commands against the screen store and drive the result register.
  tcw_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (pop_valid),
    .cmd_ready    (pop_ready),
    .cmd          (pop_cmd),
    .initializing (initializing),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .cursor_cell  (cursor_cell),
    .read_char    (read_char),
    .scrolled     (scrolled)
  );

endmodule

@@ src/tcw_front.sv @@
// Front end: takes request items and classifies them into engine commands.
// Depends on tcw_pkg.
module tcw_front (
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [1:0]                mode,
  input  logic [7:0]                character,
  input  logic [10:0]               cell_index,
  input  logic                      initializing,
  input  logic                      push_ready,
  output logic                      push_valid,
  output tcw_pkg::cmd_t             push_cmd
);

  logic in_range;

  assign in_range   = (cell_index < 11'(tcw_pkg::CELLS));
  assign req_ready  = push_ready && !initializing;
  assign push_valid = req_valid && req_ready;

  always_comb begin
    push_cmd.ch  = character;
    push_cmd.idx = tcw_pkg::CUR_W'(cell_index);
    unique case (mode)
      tcw_pkg::MODE_PUT: begin
        if (character == tcw_pkg::NUL) begin
          push_cmd.op = tcw_pkg::OP_NOP;
        end else if (character == tcw_pkg::NEWLINE) begin
          push_cmd.op = tcw_pkg::OP_NEWLINE;
        end else begin
          push_cmd.op = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::MODE_BACK:  push_cmd.op = tcw_pkg::OP_BACK;
      tcw_pkg::MODE_CLEAR: push_cmd.op = tcw_pkg::OP_CLEAR;
      default: begin
        push_cmd.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_READ_NONE;
      end
    endcase
  end

endmodule

@@ src/tcw_cmd_queue.sv @@
// Short command queue between the front end and the engine.
// Depends on tcw_pkg for the command type and depth.
module tcw_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tcw_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(tcw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

  tcw_pkg::cmd_t    entries [tcw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/tcw_engine.sv @@
// Back end: screen store, cursor, scroll/clear sequencer and result register.
// Depends on tcw_pkg.
module tcw_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  tcw_pkg::cmd_t             cmd,
  output logic                      initializing,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic [10:0]               cursor_cell,
  output logic [7:0]                read_char,
  output logic                      scrolled
);

  localparam int CW = tcw_pkg::CUR_W;
  localparam int KW = tcw_pkg::COL_W;
  localparam logic [CW-1:0] CELLS_C   = CW'(tcw_pkg::CELLS);
  localparam logic [CW-1:0] COLUMNS_C = CW'(tcw_pkg::COLUMNS);
  localparam logic [KW-1:0] LAST_COL  = KW'(tcw_pkg::COLUMNS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_COPY = 5'b00100,
    ST_FILL = 5'b01000,
    ST_PUT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    FK_INIT   = 2'd0,
    FK_CLEAR  = 2'd1,
    FK_SCROLL = 2'd2
  } fill_kind_t;

  logic [7:0]    mem [tcw_pkg::CELLS];
  logic [7:0]    rdata;

  state_t        state, state_next;
  fill_kind_t    kind, kind_next;
  logic [CW-1:0] cursor, cursor_next;
  logic [KW-1:0] col, col_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [7:0]    pend_ch, pend_ch_next;
  logic          pend_nl, pend_nl_next;

  logic          re, we;
  logic [CW-1:0] raddr, waddr;
  logic [7:0]    wdata;

  logic          out_free;
  logic          res_load;
  logic [7:0]    res_rd;
  logic          res_scr;

  // Put step on the current cursor, shared by the plain path and the
  // post-scroll path.
  logic          step_nl;
  logic [7:0]    step_ch;
  logic [CW-1:0] step_cursor;
  logic [KW-1:0] step_col;
  logic [CW-1:0] col_ext;

  assign col_ext = {{(CW-KW){1'b0}}, col};
  assign out_free = !rsp_valid || rsp_ready;
  assign initializing = (state == ST_FILL) && (kind == FK_INIT);
  assign step_nl = (state == ST_PUT) ? pend_nl : (cmd.op == tcw_pkg::OP_NEWLINE);
  assign step_ch = (state == ST_PUT) ? pend_ch : cmd.ch;

  always_comb begin
    if (step_nl) begin
      step_cursor = cursor - col_ext + COLUMNS_C;
      step_col    = '0;
    end else begin
      step_cursor = cursor + 1'b1;
      step_col    = (col == LAST_COL) ? '0 : col + 1'b1;
    end
  end

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    cursor_next  = cursor;
    col_next     = col;
    cnt_next     = cnt;
    pend_ch_next = pend_ch;
    pend_nl_next = pend_nl;
    re           = 1'b0;
    raddr        = cnt;
    we           = 1'b0;
    waddr        = cursor;
    wdata        = step_ch;
    cmd_ready    = 1'b0;
    res_load     = 1'b0;
    res_rd       = '0;
    res_scr      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE: begin
              if (cursor == CELLS_C) begin
                // Past the end: scroll first, finish the put afterwards.
                pend_ch_next = cmd.ch;
                pend_nl_next = (cmd.op == tcw_pkg::OP_NEWLINE);
                cnt_next     = COLUMNS_C;
                state_next   = ST_COPY;
              end else begin
                we          = !step_nl;
                cursor_next = step_cursor;
                col_next    = step_col;
                res_load    = 1'b1;
              end
            end
            tcw_pkg::OP_BACK: begin
              if (cursor != '0) begin
                cursor_next = cursor - 1'b1;
                col_next    = (col == '0) ? LAST_COL : col - 1'b1;
                we          = 1'b1;
                waddr       = cursor - 1'b1;
                wdata       = tcw_pkg::BLANK;
              end
              res_load = 1'b1;
            end
            tcw_pkg::OP_CLEAR: begin
              cnt_next   = '0;
              kind_next  = FK_CLEAR;
              state_next = ST_FILL;
            end
            tcw_pkg::OP_READ: begin
              re         = 1'b1;
              raddr      = cmd.idx;
              state_next = ST_READ;
            end
            default: begin
              // Null put and out-of-range read report the cursor as it is.
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load   = 1'b1;
        res_rd     = rdata;
        state_next = ST_IDLE;
      end
      ST_COPY: begin
        // Read one cell a cycle, write the previous read one row up.
        re    = (cnt < CELLS_C);
        raddr = cnt;
        we    = (cnt > COLUMNS_C);
        waddr = cnt - COLUMNS_C - 1'b1;
        wdata = rdata;
        if (cnt == CELLS_C) begin
          cnt_next   = CELLS_C - COLUMNS_C;
          kind_next  = FK_SCROLL;
          state_next = ST_FILL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = tcw_pkg::BLANK;
        if (cnt == CELLS_C - 1'b1) begin
          unique case (kind)
            FK_CLEAR: begin
              cursor_next = '0;
              col_next    = '0;
              res_load    = 1'b1;
              state_next  = ST_IDLE;
            end
            FK_SCROLL: begin
              cursor_next = cursor - COLUMNS_C;
              state_next  = ST_PUT;
            end
            default: state_next = ST_IDLE;
          endcase
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_PUT: begin
        we          = !step_nl;
        cursor_next = step_cursor;
        col_next    = step_col;
        res_load    = 1'b1;
        res_scr     = 1'b1;
        state_next  = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      kind      <= FK_INIT;
      cnt       <= '0;
      cursor    <= '0;
      col       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      kind   <= kind_next;
      cnt    <= cnt_next;
      cursor <= cursor_next;
      col    <= col_next;
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_ch <= pend_ch_next;
    pend_nl <= pend_nl_next;
    if (res_load) begin
      cursor_cell <= 11'(cursor_next);
      read_char   <= res_rd;
      scrolled    <= res_scr;
    end
  end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for text_console_writer_core: put, backspace, clear and read
// traffic with random gaps on both handshakes, checked against an in-bench screen model.
// Depends on tcw_pkg (sizes, blank and newline bytes, mode codes) and the core itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest quiet stretch allowed: the reset clearing pass and a scroll or clear each
  // walk about 2000 cells; add the longest stall on either side and a wide margin.
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [10:0] cursor_cell;
    logic [7:0]  read_char;
    logic        scrolled;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  mode = tcw_pkg::MODE_PUT;
  logic [7:0]  character = 8'h00;
  logic [10:0] cell_index = 11'd0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [10:0] cursor_cell;
  logic [7:0]  read_char;
  logic        scrolled;

  // Screen model: character store and cursor, updated as each item is accepted.
  logic [7:0]      screen_model [tcw_pkg::CELLS];
  int              cursor_model;
  console_result_t pending_results [$];

  bit stall_en = 1'b1;
  int mismatches = 0;
  int quiet_cycles = 0;

  text_console_writer_core uut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .mode       (mode),
    .character  (character),
    .cell_index (cell_index),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .cursor_cell(cursor_cell),
    .read_char  (read_char),
    .scrolled   (scrolled)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Blank every cell and home the cursor: reset state and the clear command.
  function automatic void blank_screen();
    for (int k = 0; k < tcw_pkg::CELLS; k++) screen_model[k] = tcw_pkg::BLANK;
    cursor_model = 0;
  endfunction

  // Apply one accepted item to the screen model and return the result it must produce.
  function automatic console_result_t console_step(logic [1:0] m, logic [7:0] c,
                                                   logic [10:0] idx);
    console_result_t r;
    r.read_char = 8'h00;
    r.scrolled  = 1'b0;
    case (m)
      tcw_pkg::MODE_PUT: begin
        // A null byte is dropped outright: no scroll, no store, no cursor move.
        if (c != tcw_pkg::NUL) begin
          // Cursor past the last cell: shift rows up, blank the bottom row first.
          if (cursor_model >= tcw_pkg::CELLS) begin
            for (int k = 0; k < tcw_pkg::CELLS - tcw_pkg::COLUMNS; k++) begin
              screen_model[k] = screen_model[k + tcw_pkg::COLUMNS];
            end
            for (int k = tcw_pkg::CELLS - tcw_pkg::COLUMNS; k < tcw_pkg::CELLS; k++) begin
              screen_model[k] = tcw_pkg::BLANK;
            end
            cursor_model -= tcw_pkg::COLUMNS;
            r.scrolled = 1'b1;
          end
          // Newline on the bottom row lands past the end again.
          if (c == tcw_pkg::NEWLINE) begin
            cursor_model = (cursor_model / tcw_pkg::COLUMNS + 1) * tcw_pkg::COLUMNS;
          end else begin
            if (cursor_model < tcw_pkg::CELLS) screen_model[cursor_model] = c;
            cursor_model++;
          end
        end
      end
      tcw_pkg::MODE_BACK: begin
        // Backspace past the end steps onto the last cell without scrolling.
        if (cursor_model > 0) begin
          cursor_model--;
          if (cursor_model < tcw_pkg::CELLS) screen_model[cursor_model] = tcw_pkg::BLANK;
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        blank_screen();
      end
      default: begin
        // Reads beyond the store return zero.
        if (idx < tcw_pkg::CELLS) r.read_char = screen_model[idx];
      end
    endcase
    r.cursor_cell = cursor_model[10:0];
    return r;
  endfunction

  // Present one item, hold it until taken, then log the result it must produce.
  // Called right after a rising edge; valid stays high into the next item unless
  // a gap is drawn here.
  task automatic send_item(logic [1:0] m, logic [7:0] c, logic [10:0] idx);
    if (stall_en && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid  <= 1'b1;
    mode       <= m;
    character  <= c;
    cell_index <= idx;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_results.push_back(console_step(m, c, idx));
  endtask

  // Power-on state: blank store, cursor home, null put and backspace at home change
  // nothing, reads beyond the store give zero.
  task automatic test_power_on();
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'd0);
    send_item(tcw_pkg::MODE_READ, 8'hff, 11'(tcw_pkg::CELLS - 1));
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'(tcw_pkg::CELLS));
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'h7ff);
    send_item(tcw_pkg::MODE_BACK, 8'h41, 11'd5);
    send_item(tcw_pkg::MODE_PUT, tcw_pkg::NUL, 11'd0);
  endtask

  // Store extreme bytes, read them back, newline, backspace across a row start.
  task automatic test_put_and_back();
    send_item(tcw_pkg::MODE_PUT, 8'h48, 11'd0);
    send_item(tcw_pkg::MODE_PUT, 8'hff, 11'h7ff);
    send_item(tcw_pkg::MODE_PUT, 8'h01, 11'd0);
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'd0);
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'd1);
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'd2);
    send_item(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE, 11'd0);
    send_item(tcw_pkg::MODE_BACK, 8'h00, 11'd0);
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'(tcw_pkg::COLUMNS - 1));
    send_item(tcw_pkg::MODE_BACK, 8'h00, 11'd0);
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'd2);
  endtask

  // Walk the cursor past the end with newlines, then scroll by newline and by a
  // printable byte, and back up from past the end.
  task automatic test_bottom_edge();
    send_item(tcw_pkg::MODE_PUT, 8'h5a, 11'd0);
    repeat (tcw_pkg::ROWS) send_item(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE, 11'd0);
    send_item(tcw_pkg::MODE_PUT, tcw_pkg::NUL, 11'd0);
    send_item(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE, 11'd0);
    send_item(tcw_pkg::MODE_PUT, 8'h7e, 11'd0);
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'(tcw_pkg::CELLS - tcw_pkg::COLUMNS));
    send_item(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE, 11'd0);
    send_item(tcw_pkg::MODE_BACK, 8'h00, 11'd0);
    send_item(tcw_pkg::MODE_PUT, 8'h80, 11'd0);
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'(tcw_pkg::CELLS - 1));
    send_item(tcw_pkg::MODE_CLEAR, 8'h00, 11'd0);
    send_item(tcw_pkg::MODE_READ, 8'h00, 11'(tcw_pkg::CELLS - 1));
  endtask

  // Text-like random traffic: mostly printable bytes with frequent newlines so the
  // screen fills and scrolls often; backspaces, reads near the cursor, rare clears
  // and some fully random items on top.
  task automatic test_random_text(int count);
    logic [1:0]  m;
    logic [7:0]  c;
    logic [10:0] idx;
    int          pick;
    int          near;
    repeat (count) begin
      pick = $urandom_range(0, 999);
      m    = tcw_pkg::MODE_PUT;
      c    = 8'($urandom_range(8'h21, 8'h7e));
      idx  = 11'($urandom_range(0, 2047));
      if (pick < 4) begin
        m = tcw_pkg::MODE_CLEAR;
      end else if (pick < 80) begin
        m = tcw_pkg::MODE_BACK;
      end else if (pick < 220) begin
        m = tcw_pkg::MODE_READ;
        case ($urandom_range(0, 3))
          0: idx = 11'($urandom_range(0, 2047));
          3: idx = 11'($urandom_range(tcw_pkg::CELLS - tcw_pkg::COLUMNS,
                                      tcw_pkg::CELLS - 1));
          default: begin
            near = cursor_model - int'($urandom_range(1, 40));
            idx  = 11'((near < 0) ? 0 : near);
          end
        endcase
      end else if (pick < 260) begin
        m = 2'($urandom_range(0, 3));
        c = 8'($urandom_range(0, 255));
      end else if (pick < 380) begin
        c = tcw_pkg::NEWLINE;
      end else if (pick < 500) begin
        c = 8'($urandom_range(1, 255));
      end
      send_item(m, c, idx);
    end
  endtask

  // Response side: stall in bursts while gaps are enabled, otherwise always ready.
  initial begin
    @(posedge clk);
    forever begin
      if (stall_en && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin
    console_result_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: cursor_cell %0d read_char %0d scrolled %0d",
                 $time, cursor_cell, read_char, scrolled);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (cursor_cell !== want.cursor_cell) begin
          $display("%0t: cursor_cell expected %0d, actual %0d",
                   $time, want.cursor_cell, cursor_cell);
          mismatches++;
        end
        if (read_char !== want.read_char) begin
          $display("%0t: read_char expected %0d, actual %0d",
                   $time, want.read_char, read_char);
          mismatches++;
        end
        if (scrolled !== want.scrolled) begin
          $display("%0t: scrolled expected %0d, actual %0d",
                   $time, want.scrolled, scrolled);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    blank_screen();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_power_on();
    test_put_and_back();
    test_bottom_edge();
    test_random_text(1200);
    // Run the tail with both sides at full rate.
    stall_en = 1'b0;
    test_random_text(300);
    req_valid <= 1'b0;

    // Drain outstanding results, then give stray results time to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
